### sv/spdl_pkg.sv
// ============================================================================
// spdl_pkg
// Shared types and constants of the sorted pair distance list.
// ============================================================================
package spdl_pkg;

    localparam int DIST_W = 32;
    localparam int ID_W   = 10;
    localparam int CMD_W  = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes on the input port
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_DELETE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [DIST_W-1:0] distance;
        logic [ID_W-1:0]   id_a;
        logic [ID_W-1:0]   id_b;
    } t_item;

    typedef enum logic {
        ST_IDLE,
        ST_SORT
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_MARK,
        CELL_SWAP,
        CELL_FINISH
    } t_cell_op;

endpackage

### sv/sorted_pair_distance_list_core.sv
// ============================================================================
// sorted_pair_distance_list_core
// Bounded list of the smallest pair distances, kept in ascending order.
// ============================================================================
// Usage:
//   Commands enter on start/busy: one is taken at each edge where start is
//   high and busy is low. A two-entry queue decouples the command front end
//   from the cell array, so busy rises only when that queue is full.
//   Every command yields one result (the head entry) on o_head_*, valid for
//   the single cycle o_done is high; the receiver cannot stall it.
//   Clear, insert and the unused code pass through the queue and the
//   registered o_done, and sustain one command per cycle while no delete
//   is compacting the list. Delete first marks matching cells, then
//   odd-even swap passes move the marked cells to the tail, ending early
//   once the list is compact, and a final step refills them.
//   fill_distance is written on i_cfg_valid (o_cfg_ready is always high).
//   The user writes it only while no command is in flight (not enforced).
//   Reset (synchronous, active low) empties the queue, sets every entry to
//   all-ones distance with zero ids, and sets fill_distance to all ones.
// ============================================================================
module sorted_pair_distance_list_core #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [spdl_pkg::CMD_W-1:0]   i_command,
    input  logic [spdl_pkg::DIST_W-1:0]  i_new_distance,
    input  logic [spdl_pkg::ID_W-1:0]    i_particle_a,
    input  logic [spdl_pkg::ID_W-1:0]    i_particle_b,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [spdl_pkg::DIST_W-1:0]  i_cfg_data,
    output logic                         o_done,
    output logic [spdl_pkg::DIST_W-1:0]  o_head_distance,
    output logic [spdl_pkg::ID_W-1:0]    o_head_first,
    output logic [spdl_pkg::ID_W-1:0]    o_head_second
);

    logic            w_q_valid;
    spdl_pkg::t_item w_q_item;
    logic            w_q_pop;

    assign o_cfg_ready = 1'b1;

    spdl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_command      (i_command),
        .i_new_distance (i_new_distance),
        .i_particle_a   (i_particle_a),
        .i_particle_b   (i_particle_b),
        .o_q_valid      (w_q_valid),
        .o_q_item       (w_q_item),
        .i_q_pop        (w_q_pop)
    );

    spdl_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_head_distance (o_head_distance),
        .o_head_first    (o_head_first),
        .o_head_second   (o_head_second)
    );

endmodule

### sv/spdl_front.sv
// ============================================================================
// spdl_front
// Command front end: decodes each accepted command and holds it in a short
// queue until the list back end takes it.
// ============================================================================
module spdl_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [spdl_pkg::CMD_W-1:0]   i_command,
    input  logic [spdl_pkg::DIST_W-1:0]  i_new_distance,
    input  logic [spdl_pkg::ID_W-1:0]    i_particle_a,
    input  logic [spdl_pkg::ID_W-1:0]    i_particle_b,
    output logic                         o_q_valid,
    output spdl_pkg::t_item              o_q_item,
    input  logic                         i_q_pop
);

    spdl_pkg::t_item                 r_q [spdl_pkg::QUEUE_DEPTH];
    logic [spdl_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [spdl_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [spdl_pkg::QCNT_W-1:0]     r_count;
    logic                            w_push;
    spdl_pkg::t_item                 w_item;

    always_comb begin
        w_item.distance = i_new_distance;
        w_item.id_a     = i_particle_a;
        w_item.id_b     = i_particle_b;
        unique case (i_command)
            spdl_pkg::CMD_CLEAR:  w_item.op = spdl_pkg::OP_CLEAR;
            spdl_pkg::CMD_INSERT: w_item.op = spdl_pkg::OP_INSERT;
            spdl_pkg::CMD_DELETE: w_item.op = spdl_pkg::OP_DELETE;
            default:              w_item.op = spdl_pkg::OP_NOP;
        endcase
    end

    assign o_busy    = (r_count == spdl_pkg::QCNT_W'(spdl_pkg::QUEUE_DEPTH));
    assign w_push    = i_start && !o_busy;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == spdl_pkg::QPTR_W'(spdl_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == spdl_pkg::QPTR_W'(spdl_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spdl_pkg::QCNT_W'(spdl_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push without pop did not grow queue");

endmodule

### sv/spdl_back.sv
// ============================================================================
// spdl_back
// List back end: a row of compare-and-shift cells holding the sorted list.
// Insert and clear rewrite the cells directly; delete marks matching cells, then
// bubbles marked cells to the tail by odd-even swaps and refills them.
// ============================================================================
module spdl_back #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  spdl_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    input  logic                         i_cfg_valid,
    input  logic [spdl_pkg::DIST_W-1:0]  i_cfg_data,
    output logic                         o_done,
    output logic [spdl_pkg::DIST_W-1:0]  o_head_distance,
    output logic [spdl_pkg::ID_W-1:0]    o_head_first,
    output logic [spdl_pkg::ID_W-1:0]    o_head_second
);

    logic [spdl_pkg::DIST_W-1:0] r_dist [LIST_DEPTH];
    logic [spdl_pkg::ID_W-1:0]   r_ida  [LIST_DEPTH];
    logic [spdl_pkg::ID_W-1:0]   r_idb  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]       r_dead;
    logic [spdl_pkg::DIST_W-1:0] n_dist [LIST_DEPTH];
    logic [spdl_pkg::ID_W-1:0]   n_ida  [LIST_DEPTH];
    logic [spdl_pkg::ID_W-1:0]   n_idb  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]       n_dead;

    logic [spdl_pkg::DIST_W-1:0] r_fill;
    spdl_pkg::t_state            r_state;
    spdl_pkg::t_state            n_state;
    logic                        r_phase;
    logic                        n_phase;
    logic                        r_done;
    logic                        n_done;
    spdl_pkg::t_cell_op          w_cell_op;

    logic [LIST_DEPTH-1:0]       w_le;
    logic [LIST_DEPTH-1:0]       w_any_ge;
    logic                        w_sorted;

    // a marked cell below a live one means compaction is not finished
    assign w_sorted = ~|(r_dead[LIST_DEPTH-2:0] & ~r_dead[LIST_DEPTH-1:1]);

    always_comb begin
        for (int k = 0; k < LIST_DEPTH; k++) begin
            w_le[k] = (r_dist[k] <= i_q_item.distance);
        end
        // any_ge[k]: some cell at or above k is <= new distance
        for (int k = 0; k < LIST_DEPTH; k++) begin
            w_any_ge[k] = |(w_le >> k);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spdl_pkg::ST_IDLE: begin
                if (i_q_valid && i_q_item.op == spdl_pkg::OP_DELETE) begin
                    n_state = spdl_pkg::ST_SORT;
                end
            end
            spdl_pkg::ST_SORT: begin
                if (w_sorted) begin
                    n_state = spdl_pkg::ST_IDLE;
                end
            end
            default: n_state = spdl_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop   = 1'b0;
        n_done    = 1'b0;
        n_phase   = 1'b0;
        w_cell_op = spdl_pkg::CELL_HOLD;
        unique case (r_state)
            spdl_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.op)
                        spdl_pkg::OP_CLEAR: begin
                            w_cell_op = spdl_pkg::CELL_CLEAR;
                            n_done    = 1'b1;
                        end
                        spdl_pkg::OP_INSERT: begin
                            w_cell_op = spdl_pkg::CELL_INSERT;
                            n_done    = 1'b1;
                        end
                        spdl_pkg::OP_DELETE: begin
                            w_cell_op = spdl_pkg::CELL_MARK;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            spdl_pkg::ST_SORT: begin
                if (w_sorted) begin
                    w_cell_op = spdl_pkg::CELL_FINISH;
                    n_done    = 1'b1;
                end else begin
                    w_cell_op = spdl_pkg::CELL_SWAP;
                    n_phase   = ~r_phase;
                end
            end
            default: ;
        endcase
    end

    // cell update
    always_comb begin
        for (int k = 0; k < LIST_DEPTH; k++) begin
            n_dist[k] = r_dist[k];
            n_ida[k]  = r_ida[k];
            n_idb[k]  = r_idb[k];
        end
        n_dead = r_dead;
        case (w_cell_op)
            spdl_pkg::CELL_CLEAR: begin
                for (int k = 0; k < LIST_DEPTH; k++) begin
                    n_dist[k] = r_fill;
                    n_ida[k]  = '0;
                    n_idb[k]  = '0;
                end
                n_dead = '0;
            end
            spdl_pkg::CELL_INSERT: begin
                if (!w_le[LIST_DEPTH-1]) begin
                    if (!w_any_ge[0]) begin
                        n_dist[0] = i_q_item.distance;
                        n_ida[0]  = i_q_item.id_a;
                        n_idb[0]  = i_q_item.id_b;
                    end
                    for (int k = 1; k < LIST_DEPTH; k++) begin
                        if (!w_any_ge[k]) begin
                            if (w_le[k-1]) begin
                                n_dist[k] = i_q_item.distance;
                                n_ida[k]  = i_q_item.id_a;
                                n_idb[k]  = i_q_item.id_b;
                            end else begin
                                n_dist[k] = r_dist[k-1];
                                n_ida[k]  = r_ida[k-1];
                                n_idb[k]  = r_idb[k-1];
                            end
                        end
                    end
                end
            end
            spdl_pkg::CELL_MARK: begin
                for (int k = 0; k < LIST_DEPTH; k++) begin
                    n_dead[k] = (r_ida[k] == i_q_item.id_a) || (r_idb[k] == i_q_item.id_a);
                end
            end
            spdl_pkg::CELL_SWAP: begin
                // disjoint pairs (k, k+1) of the current parity
                for (int k = 0; k < LIST_DEPTH - 1; k++) begin
                    if (((k % 2) == int'(r_phase)) && r_dead[k] && !r_dead[k+1]) begin
                        n_dist[k]   = r_dist[k+1];
                        n_ida[k]    = r_ida[k+1];
                        n_idb[k]    = r_idb[k+1];
                        n_dead[k]   = 1'b0;
                        n_dead[k+1] = 1'b1;
                    end
                end
            end
            spdl_pkg::CELL_FINISH: begin
                for (int k = 0; k < LIST_DEPTH; k++) begin
                    if (r_dead[k]) begin
                        n_dist[k] = r_fill;
                        n_ida[k]  = '0;
                        n_idb[k]  = '0;
                    end
                end
                n_dead = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LIST_DEPTH; k++) begin
                r_dist[k] <= '1;
                r_ida[k]  <= '0;
                r_idb[k]  <= '0;
            end
            r_dead  <= '0;
            r_fill  <= '1;
            r_state <= spdl_pkg::ST_IDLE;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_dist  <= n_dist;
            r_ida   <= n_ida;
            r_idb   <= n_idb;
            r_dead  <= n_dead;
            r_state <= n_state;
            r_phase <= n_phase;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_fill <= i_cfg_data;
            end
        end
    end

    assign o_done          = r_done;
    assign o_head_distance = r_dist[0];
    assign o_head_first    = r_ida[0];
    assign o_head_second   = r_idb[0];

    a_pop_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (i_q_valid && r_state == spdl_pkg::ST_IDLE))
        else $error("command taken outside idle");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_dead == '0))
        else $error("result reported with marked cells left");

    a_no_done_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spdl_pkg::ST_SORT && $past(r_state) == spdl_pkg::ST_SORT) |-> !r_done)
        else $error("result strobe during compaction");

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sorted_pair_distance_list_core
// Drives clear, insert, delete and unused commands through the start/busy
// port and checks each head result against a local list model. A short
// directed table covers extremes and the special cases. Random phases follow,
// each with its own fill distance.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 64;
    localparam int TAIL_CYCLES = DEPTH + 8;
    localparam int PHASE_ITEMS = 190;
    localparam int NUM_PHASES  = 5;
    localparam logic [spdl_pkg::CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [spdl_pkg::DIST_W-1:0] DIST_MAX   = '1;
    localparam logic [spdl_pkg::ID_W-1:0]   ID_MAX     = '1;

    typedef struct packed {
        logic [spdl_pkg::DIST_W-1:0] distance;
        logic [spdl_pkg::ID_W-1:0]   first;
        logic [spdl_pkg::ID_W-1:0]   second;
    } t_head;

    typedef struct packed {
        logic [spdl_pkg::CMD_W-1:0]  cmd;
        logic [spdl_pkg::DIST_W-1:0] distance;
        logic [spdl_pkg::ID_W-1:0]   a;
        logic [spdl_pkg::ID_W-1:0]   b;
        bit                          known;
        t_head                       head;
    } t_dir_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [spdl_pkg::CMD_W-1:0]  i_command;
    logic [spdl_pkg::DIST_W-1:0] i_new_distance;
    logic [spdl_pkg::ID_W-1:0]   i_particle_a;
    logic [spdl_pkg::ID_W-1:0]   i_particle_b;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [spdl_pkg::DIST_W-1:0] i_cfg_data;
    logic                        o_done;
    logic [spdl_pkg::DIST_W-1:0] o_head_distance;
    logic [spdl_pkg::ID_W-1:0]   o_head_first;
    logic [spdl_pkg::ID_W-1:0]   o_head_second;

    // local copy of the list and the fill register
    logic [spdl_pkg::DIST_W-1:0] list_dist   [DEPTH];
    logic [spdl_pkg::ID_W-1:0]   list_first  [DEPTH];
    logic [spdl_pkg::ID_W-1:0]   list_second [DEPTH];
    logic [spdl_pkg::DIST_W-1:0] fill_dist;

    t_head expected_heads[$];
    int    errors          = 0;
    int    heads_checked   = 0;
    int    cmd_count[4]    = '{default: 0};
    int    fill_writes     = 0;

    sorted_pair_distance_list_core #(
        .LIST_DEPTH (DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_new_distance  (i_new_distance),
        .i_particle_a    (i_particle_a),
        .i_particle_b    (i_particle_b),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_head_distance (o_head_distance),
        .o_head_first    (o_head_first),
        .o_head_second   (o_head_second)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_head apply_list_command(input logic [spdl_pkg::CMD_W-1:0] cmd,
                                                 input logic [spdl_pkg::DIST_W-1:0] d,
                                                 input logic [spdl_pkg::ID_W-1:0] a,
                                                 input logic [spdl_pkg::ID_W-1:0] b);
        int pos;
        int w;
        pos = 0;
        w   = 0;
        case (cmd)
            spdl_pkg::CMD_CLEAR: begin
                for (int k = 0; k < DEPTH; k++) begin
                    list_dist[k]   = fill_dist;
                    list_first[k]  = '0;
                    list_second[k] = '0;
                end
            end
            spdl_pkg::CMD_INSERT: begin
                // new entry lands after all entries of equal distance
                for (int k = 0; k < DEPTH; k++)
                    if (list_dist[k] <= d) pos = k + 1;
                if (pos < DEPTH) begin
                    for (int k = DEPTH - 1; k > pos; k--) begin
                        list_dist[k]   = list_dist[k-1];
                        list_first[k]  = list_first[k-1];
                        list_second[k] = list_second[k-1];
                    end
                    list_dist[pos]   = d;
                    list_first[pos]  = a;
                    list_second[pos] = b;
                end
            end
            spdl_pkg::CMD_DELETE: begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (list_first[k] != a && list_second[k] != a) begin
                        list_dist[w]   = list_dist[k];
                        list_first[w]  = list_first[k];
                        list_second[w] = list_second[k];
                        w++;
                    end
                end
                for (; w < DEPTH; w++) begin
                    list_dist[w]   = fill_dist;
                    list_first[w]  = '0;
                    list_second[w] = '0;
                end
            end
            default: ;
        endcase
        return '{list_dist[0], list_first[0], list_second[0]};
    endfunction

    // start stays high between items of a burst
    task automatic send_command(input logic [spdl_pkg::CMD_W-1:0] cmd,
                                input logic [spdl_pkg::DIST_W-1:0] d,
                                input logic [spdl_pkg::ID_W-1:0] a,
                                input logic [spdl_pkg::ID_W-1:0] b,
                                input bit known,
                                input t_head head);
        t_head predicted;
        @(negedge i_clk);
        start          <= 1'b1;
        i_command      <= cmd;
        i_new_distance <= d;
        i_particle_a   <= a;
        i_particle_b   <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_list_command(cmd, d, a, b);
        expected_heads.push_back(known ? head : predicted);
        cmd_count[cmd]++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_heads.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_fill(input logic [spdl_pkg::DIST_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        fill_dist = value;
        fill_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= $urandom();
    endtask

    // small pool so deletes hit, with extremes and full range mixed in
    function automatic logic [spdl_pkg::ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return spdl_pkg::ID_W'($urandom_range(0, 15));
        if (r == 7) return ($urandom_range(0, 1) != 0) ? ID_MAX : '0;
        return spdl_pkg::ID_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [spdl_pkg::DIST_W-1:0] pick_distance();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3, 4: return spdl_pkg::DIST_W'($urandom_range(0, 255));
            5, 6:          return $urandom();
            7:             return DIST_MAX - spdl_pkg::DIST_W'($urandom_range(0, 3));
            8:             return fill_dist;
            default:       return {8'($urandom_range(0, 255)), 24'h0};
        endcase
    endfunction

    task automatic send_random_command();
        int r;
        logic [spdl_pkg::CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 3)       cmd = spdl_pkg::CMD_CLEAR;
        else if (r < 5)  cmd = CMD_UNUSED;
        else if (r < 25) cmd = spdl_pkg::CMD_DELETE;
        else             cmd = spdl_pkg::CMD_INSERT;
        send_command(cmd, pick_distance(), pick_id(), pick_id(), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_head want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_heads.size() == 0) begin
                $error("head result with no item outstanding: dist=%h first=%0d second=%0d",
                       o_head_distance, o_head_first, o_head_second);
                errors++;
            end else begin
                want = expected_heads.pop_front();
                heads_checked++;
                if (o_head_distance !== want.distance) begin
                    $error("head_distance: expected %h, got %h", want.distance,
                           o_head_distance);
                    errors++;
                end
                if (o_head_first !== want.first) begin
                    $error("head_first: expected %0d, got %0d", want.first, o_head_first);
                    errors++;
                end
                if (o_head_second !== want.second) begin
                    $error("head_second: expected %0d, got %0d", want.second, o_head_second);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", expected_heads.size());
        $display("sorted_pair_distance_list_core verification failed");
        $finish;
    end

    initial begin
        t_dir_row dir_rows[$];
        logic [spdl_pkg::DIST_W-1:0] phase_fill[NUM_PHASES];
        int sent;
        int burst;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = spdl_pkg::CMD_CLEAR;
        i_new_distance = '0;
        i_particle_a   = '0;
        i_particle_b   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;

        fill_dist = DIST_MAX;
        for (int k = 0; k < DEPTH; k++) begin
            list_dist[k]   = DIST_MAX;
            list_first[k]  = '0;
            list_second[k] = '0;
        end

        //            cmd         distance      a       b       known  head
        dir_rows = '{
            '{CMD_UNUSED, 32'h0,        10'd0,   10'd0,   1'b1, '{DIST_MAX, 10'd0, 10'd0}},
            '{spdl_pkg::CMD_INSERT, DIST_MAX, 10'd1, 10'd2, 1'b1, '{DIST_MAX, 10'd0, 10'd0}},
            '{spdl_pkg::CMD_INSERT, 32'h0, ID_MAX, ID_MAX, 1'b1, '{32'h0, ID_MAX, ID_MAX}},
            '{spdl_pkg::CMD_INSERT, 32'h0, 10'd5, 10'd6, 1'b1, '{32'h0, ID_MAX, ID_MAX}},
            '{spdl_pkg::CMD_INSERT, 32'h0100_0000, 10'd7, 10'd8, 1'b1,
              '{32'h0, ID_MAX, ID_MAX}},
            '{spdl_pkg::CMD_DELETE, 32'h0, ID_MAX, ID_MAX, 1'b1, '{32'h0, 10'd5, 10'd6}},
            '{spdl_pkg::CMD_INSERT, 32'h0080_0000, 10'd5, 10'd9, 1'b1,
              '{32'h0, 10'd5, 10'd6}},
            '{spdl_pkg::CMD_INSERT, 32'h0080_0000, 10'd9, 10'd5, 1'b0, '0},
            // adjacent matches, both id positions
            '{spdl_pkg::CMD_DELETE, 32'h0, 10'd5, 10'd0, 1'b1,
              '{32'h0100_0000, 10'd7, 10'd8}},
            // vacated entries carry id 0
            '{spdl_pkg::CMD_DELETE, 32'h0, 10'd0, 10'd0, 1'b1,
              '{32'h0100_0000, 10'd7, 10'd8}},
            '{spdl_pkg::CMD_INSERT, DIST_MAX - 1, 10'h2AA, 10'h155, 1'b0, '0},
            '{spdl_pkg::CMD_CLEAR, DIST_MAX, ID_MAX, ID_MAX, 1'b1, '{DIST_MAX, 10'd0, 10'd0}},
            '{spdl_pkg::CMD_INSERT, DIST_MAX - 1, 10'h155, 10'h2AA, 1'b1,
              '{DIST_MAX - 1, 10'h155, 10'h2AA}},
            '{spdl_pkg::CMD_DELETE, 32'h0, 10'h2AA, 10'd0, 1'b1, '{DIST_MAX, 10'd0, 10'd0}},
            '{CMD_UNUSED, DIST_MAX,     ID_MAX,  ID_MAX,  1'b1, '{DIST_MAX, 10'd0, 10'd0}},
            '{spdl_pkg::CMD_INSERT, 32'h5555_5555, 10'h155, 10'h2AA, 1'b0, '0},
            '{spdl_pkg::CMD_INSERT, 32'hAAAA_AAAA, 10'h2AA, 10'h155, 1'b0, '0},
            '{spdl_pkg::CMD_DELETE, 32'h0, 10'h155, 10'h3FF, 1'b0, '0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_command(dir_rows[i].cmd, dir_rows[i].distance, dir_rows[i].a,
                         dir_rows[i].b, dir_rows[i].known, dir_rows[i].head);
            pause_sender($urandom_range(0, 2));
        end

        phase_fill[0] = $urandom();
        phase_fill[1] = '0;
        phase_fill[2] = 32'h0100_0000;
        phase_fill[3] = spdl_pkg::DIST_W'($urandom_range(0, 255));
        phase_fill[4] = DIST_MAX;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_fill(phase_fill[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // long bursts now and then give stretches with no idling
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
                for (int j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
                    send_random_command();
                    sent++;
                end
                if ($urandom_range(0, 29) == 0)
                    drain_results();
                else
                    pause_sender($urandom_range(0, 7));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d clears, %0d inserts, %0d deletes, %0d unused codes",
                 cmd_count[spdl_pkg::CMD_CLEAR], cmd_count[spdl_pkg::CMD_INSERT],
                 cmd_count[spdl_pkg::CMD_DELETE], cmd_count[CMD_UNUSED]);
        $display("%0d head results checked over %0d fill distance settings, %0d errors",
                 heads_checked, fill_writes, errors);
        if (errors == 0 && expected_heads.size() == 0) begin
            $display("sorted_pair_distance_list_core verification clean");
        end else begin
            $display("sorted_pair_distance_list_core verification failed");
        end
        $finish;
    end

endmodule

### files.f
sv/spdl_pkg.sv
sv/spdl_front.sv
sv/spdl_back.sv
sv/sorted_pair_distance_list_core.sv
bench/testbench.sv
